>>> src/aur_pkg.sv
// Package: shared widths, constants and stage-to-stage structs of the u update pipeline
`timescale 1ns / 1ps
package aur_pkg;

    // widths of the fixed-point datapath
    localparam int PIX_W   = 16;            // Q2.14 pixel values
    localparam int G_W     = 15;            // observed value g
    localparam int COEF_W  = 16;            // beta and gamma
    localparam int WSQ_W   = 19;            // rounded squared edge weight, Q.16
    localparam int NUM_W   = 56;            // dividend magnitude plus rounding offset
    localparam int DEN_W   = 37;            // denominator, Q.28
    localparam int QUO_B   = 17;            // quotient bits resolved by the divider
    localparam int SQC_W   = 30;            // squared change
    localparam int CIDX_W  = 2;             // configuration index

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_BETA  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_GAMMA = 2'd1;

    // reset values of the configuration registers
    localparam logic [COEF_W-1:0] BETA_RST  = 16'd2048;
    localparam logic [COEF_W-1:0] GAMMA_RST = 16'd16384;

    // one in Q.28 for the denominator, one in Q1.15 for the blend
    localparam logic [DEN_W-1:0]  DEN_ONE   = 37'h0_1000_0000;
    localparam logic signed [17:0] GAM_ONE  = 18'sd32768;

    // edge order inside the weight arrays
    localparam int EDGE_E = 0;
    localparam int EDGE_W = 1;
    localparam int EDGE_N = 2;
    localparam int EDGE_S = 3;

    // one pixel neighbourhood as it enters the pipeline
    typedef struct packed {
        logic signed [PIX_W-1:0] u_center;
        logic signed [PIX_W-1:0] u_east;
        logic signed [PIX_W-1:0] u_west;
        logic signed [PIX_W-1:0] u_north;
        logic signed [PIX_W-1:0] u_south;
        logic        [G_W-1:0]   g_value;
        logic signed [PIX_W-1:0] v_top_left;
        logic signed [PIX_W-1:0] v_top_right;
        logic signed [PIX_W-1:0] v_bottom_left;
        logic signed [PIX_W-1:0] v_bottom_right;
        logic                    on_border;
    } t_in_item;

    // fields that ride alongside the division
    typedef struct packed {
        logic signed [PIX_W-1:0] u_center;
        logic                    on_border;
        logic                    neg;
    } t_side;

endpackage

>>> src/aur_if.sv
// Interfaces: valid/ready channels for pixel neighbourhoods and update results
`timescale 1ns / 1ps
interface aur_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] u_center;
    logic signed [15:0] u_east;
    logic signed [15:0] u_west;
    logic signed [15:0] u_north;
    logic signed [15:0] u_south;
    logic        [14:0] g_value;
    logic signed [15:0] v_top_left;
    logic signed [15:0] v_top_right;
    logic signed [15:0] v_bottom_left;
    logic signed [15:0] v_bottom_right;
    logic              on_border;

    modport source (output valid, u_center, u_east, u_west, u_north, u_south, g_value,
                    v_top_left, v_top_right, v_bottom_left, v_bottom_right, on_border,
                    input ready);
    modport sink   (input valid, u_center, u_east, u_west, u_north, u_south, g_value,
                    v_top_left, v_top_right, v_bottom_left, v_bottom_right, on_border,
                    output ready);
endinterface

interface aur_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] new_u;
    logic        [29:0] squared_change;

    modport source (output valid, new_u, squared_change, input ready);
    modport sink   (input valid, new_u, squared_change, output ready);
endinterface

>>> src/aur_front.sv
// Front end: edge weights, weighted neighbour sum and denominator over four stages
`timescale 1ns / 1ps
module aur_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_valid,
    input  aur_pkg::t_in_item             i_item,
    input  logic [aur_pkg::COEF_W-1:0]    i_beta,
    output logic                          o_valid,
    output logic [aur_pkg::NUM_W-1:0]     o_num,
    output logic [aur_pkg::DEN_W-1:0]     o_den,
    output aur_pkg::t_side                o_side
);
    import aur_pkg::*;

    // rounded square of the averaged corner pair: (s^2 + 2^13) >> 14
    function automatic logic [WSQ_W-1:0] sq_weight(input logic signed [PIX_W-1:0] a,
                                                   input logic signed [PIX_W-1:0] b);
        logic signed [PIX_W:0] s;
        logic        [PIX_W:0] m;
        logic        [33:0]    p;
        s = 17'(a) + 17'(b);
        m = s[PIX_W] ? 17'(-s) : 17'(s);
        p = 34'(m) * 34'(m) + 34'd8192;
        return p[32:14];
    endfunction

    // stage 1
    logic                    r1_valid;
    logic [WSQ_W-1:0]        r1_w   [4];
    logic signed [PIX_W-1:0] r1_unb [4];
    logic [G_W-1:0]          r1_g;
    logic signed [PIX_W-1:0] r1_uc;
    logic                    r1_border;
    // stage 2
    logic                    r2_valid;
    logic [34:0]             r2_p   [4];
    logic [20:0]             r2_sumw;
    logic signed [PIX_W-1:0] r2_unb [4];
    logic [G_W-1:0]          r2_g;
    logic signed [PIX_W-1:0] r2_uc;
    logic                    r2_border;
    // stage 3
    logic                    r3_valid;
    logic signed [51:0]      r3_t   [4];
    logic [DEN_W-1:0]        r3_den;
    logic [G_W-1:0]          r3_g;
    logic signed [PIX_W-1:0] r3_uc;
    logic                    r3_border;
    // stage 4
    logic                    r4_valid;
    logic [NUM_W-1:0]        r4_num;
    logic [DEN_W-1:0]        r4_den;
    t_side                   r4_side;

    logic signed [53:0]      n_sum;
    logic [53:0]             n_mag;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_ce) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // stage 1: squared edge weights
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_w[EDGE_E]   <= sq_weight(i_item.v_top_right, i_item.v_bottom_right);
            r1_w[EDGE_W]   <= sq_weight(i_item.v_top_left, i_item.v_bottom_left);
            r1_w[EDGE_N]   <= sq_weight(i_item.v_top_left, i_item.v_top_right);
            r1_w[EDGE_S]   <= sq_weight(i_item.v_bottom_left, i_item.v_bottom_right);
            r1_unb[EDGE_E] <= i_item.u_east;
            r1_unb[EDGE_W] <= i_item.u_west;
            r1_unb[EDGE_N] <= i_item.u_north;
            r1_unb[EDGE_S] <= i_item.u_south;
            r1_g           <= i_item.g_value;
            r1_uc          <= i_item.u_center;
            r1_border      <= i_item.on_border;
        end
    end

    // stage 2: beta times each weight, weight sum
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 4; k++) begin
                r2_p[k]   <= 35'(i_beta) * 35'(r1_w[k]);
                r2_unb[k] <= r1_unb[k];
            end
            r2_sumw   <= 21'(r1_w[0]) + 21'(r1_w[1]) + 21'(r1_w[2]) + 21'(r1_w[3]);
            r2_g      <= r1_g;
            r2_uc     <= r1_uc;
            r2_border <= r1_border;
        end
    end

    // stage 3: weighted neighbours, denominator
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 4; k++) begin
                r3_t[k] <= $signed({1'b0, r2_p[k]}) * r2_unb[k];
            end
            r3_den    <= DEN_ONE + 37'(i_beta) * 37'(r2_sumw);
            r3_g      <= r2_g;
            r3_uc     <= r2_uc;
            r3_border <= r2_border;
        end
    end

    // stage 4: numerator, its magnitude plus half the denominator
    always_comb begin
        n_sum = 54'($signed({1'b0, r3_g, 28'b0}))
              + 54'(r3_t[0]) + 54'(r3_t[1]) + 54'(r3_t[2]) + 54'(r3_t[3]);
        n_mag = n_sum[53] ? 54'(-n_sum) : 54'(n_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r4_num            <= 56'(n_mag) + 56'(r3_den >> 1);
            r4_den            <= r3_den;
            r4_side.u_center  <= r3_uc;
            r4_side.on_border <= r3_border;
            r4_side.neg       <= n_sum[53];
        end
    end

    assign o_valid = r4_valid;
    assign o_num   = r4_num;
    assign o_den   = r4_den;
    assign o_side  = r4_side;

    // denominator never drops below one
    a_den_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid |-> r4_den >= DEN_ONE)
        else $error("denominator below one");

endmodule

>>> src/aur_div.sv
// Divider: restoring division, one quotient bit per pipeline stage
`timescale 1ns / 1ps
module aur_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_valid,
    input  logic [aur_pkg::NUM_W-1:0]     i_num,
    input  logic [aur_pkg::DEN_W-1:0]     i_den,
    input  aur_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [aur_pkg::QUO_B-1:0]     o_quo,
    output logic                          o_ovf,
    output aur_pkg::t_side                o_side
);
    import aur_pkg::*;

    logic               r_v    [QUO_B+1];
    logic [NUM_W-1:0]   r_rem  [QUO_B+1];
    logic [DEN_W-1:0]   r_den  [QUO_B+1];
    logic [QUO_B-1:0]   r_q    [QUO_B+1];
    logic               r_ovf  [QUO_B+1];
    t_side              r_side [QUO_B+1];

    // entry stage: flag quotients that cannot fit the resolved bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_ovf[0]  <= i_num >= (NUM_W'(i_den) << QUO_B);
            r_side[0] <= i_side;
        end
    end

    // one compare and subtract per stage, most significant bit first
    for (genvar k = 1; k <= QUO_B; k++) begin : g_step
        localparam int B = QUO_B - k;
        logic [NUM_W-1:0] n_shd;
        logic             n_take;

        always_comb begin
            n_shd  = NUM_W'(r_den[k-1]) << B;
            n_take = r_rem[k-1] >= n_shd;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ce) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k]  <= n_take ? r_rem[k-1] - n_shd : r_rem[k-1];
                r_q[k]    <= r_q[k-1] | (n_take ? (QUO_B'(1) << B) : '0);
                r_den[k]  <= r_den[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[QUO_B];
    assign o_quo   = r_q[QUO_B];
    assign o_ovf   = r_ovf[QUO_B];
    assign o_side  = r_side[QUO_B];

    // a finished, in-range division leaves less than one divisor behind
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[QUO_B] && !r_ovf[QUO_B] |-> r_rem[QUO_B] < NUM_W'(r_den[QUO_B]))
        else $error("division remainder out of range");

endmodule

>>> src/aur_blend.sv
// Back end: candidate saturation, relaxation blend and squared change
`timescale 1ns / 1ps
module aur_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_valid,
    input  logic [aur_pkg::QUO_B-1:0]     i_quo,
    input  logic                          i_ovf,
    input  aur_pkg::t_side                i_side,
    input  logic [aur_pkg::COEF_W-1:0]    i_gamma,
    output logic                          o_valid,
    output logic signed [aur_pkg::PIX_W-1:0] o_new_u,
    output logic [aur_pkg::SQC_W-1:0]     o_sq
);
    import aur_pkg::*;

    logic                    r1_valid, r2_valid, r3_valid, r4_valid;
    logic signed [PIX_W-1:0] r1_cand;
    logic signed [PIX_W-1:0] r1_uc, r2_uc, r3_uc, r4_uc;
    logic signed [33:0]      r2_pa, r2_pb;
    logic signed [PIX_W-1:0] r3_nu, r4_nu;
    logic [SQC_W-1:0]        r4_sq;

    logic signed [PIX_W-1:0] n_cand;
    logic signed [17:0]      n_wold;
    logic signed [34:0]      n_mix;
    logic [34:0]             n_mmag;
    logic [19:0]             n_q2;
    logic signed [PIX_W-1:0] n_nu;
    logic signed [PIX_W:0]   n_d;
    logic [PIX_W:0]          n_dm;
    logic [33:0]             n_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_ce) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // stage 1: signed, saturated candidate; zero on the border
    always_comb begin
        if (i_side.on_border) begin
            n_cand = '0;
        end else if (i_side.neg) begin
            n_cand = (i_ovf || i_quo > 17'd32768) ? 16'sh8000
                                                  : PIX_W'(-$signed({1'b0, i_quo}));
        end else begin
            n_cand = (i_ovf || i_quo > 17'd32767) ? 16'sh7FFF : PIX_W'(i_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_cand <= n_cand;
            r1_uc   <= i_side.u_center;
        end
    end

    // stage 2: the two blend products
    assign n_wold = GAM_ONE - $signed({2'b0, i_gamma});

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_pa <= $signed({1'b0, i_gamma}) * r1_cand;
            r2_pb <= n_wold * r1_uc;
            r2_uc <= r1_uc;
        end
    end

    // stage 3: sum, round half away from zero, saturate
    always_comb begin
        n_mix  = 35'(r2_pa) + 35'(r2_pb);
        n_mmag = n_mix[34] ? 35'(-n_mix) : 35'(n_mix);
        n_q2   = 20'((n_mmag + 35'd16384) >> 15);
        if (n_mix[34]) begin
            n_nu = (n_q2 > 20'd32768) ? 16'sh8000 : PIX_W'(-$signed({1'b0, n_q2}));
        end else begin
            n_nu = (n_q2 > 20'd32767) ? 16'sh7FFF : PIX_W'(n_q2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r3_nu <= n_nu;
            r3_uc <= r2_uc;
        end
    end

    // stage 4: squared change, saturated; output register
    always_comb begin
        n_d  = 17'(r3_uc) - 17'(r3_nu);
        n_dm = n_d[PIX_W] ? 17'(-n_d) : 17'(n_d);
        n_sq = 34'(n_dm) * 34'(n_dm);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r4_nu <= r3_nu;
            r4_uc <= r3_uc;
            r4_sq <= (n_sq[33:SQC_W] != '0) ? '1 : n_sq[SQC_W-1:0];
        end
    end

    assign o_valid = r4_valid;
    assign o_new_u = r4_nu;
    assign o_sq    = r4_sq;

    // no change reported exactly when the pixel kept its value
    a_zero_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid && (r4_sq == '0) |-> r4_nu == r4_uc)
        else $error("zero change with a moved pixel");

endmodule

>>> src/at_u_relaxed_update_top.sv
// Top level: relaxed per-pixel u update, front end, divider and blend
//
//  channel  | dir | transfer when         | payload
//  ---------+-----+-----------------------+---------------------------------------
//  i_in     | in  | valid && ready        | u centre, 4 neighbours, g, 4 corners v, border
//  o_out    | out | valid && ready        | new_u, squared_change
//  cfg      | in  | i_cfg_we              | index 0 beta (Q4.12), index 1 gamma (Q1.15)
//
// One pixel per cycle unless the output stalls; 4 front stages, 18 divider stages,
// 4 blend stages. The divider resolves one quotient bit per stage.
// Reset is synchronous and clears valid bits and loads beta 0.5, gamma 0.5.
// A stall at the output freezes every stage at once; ready drops with it.
`timescale 1ns / 1ps
module at_u_relaxed_update_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    aur_in_if.sink                         i_in,
    aur_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [aur_pkg::CIDX_W-1:0]     i_cfg_idx,
    input  logic [aur_pkg::COEF_W-1:0]     i_cfg_data
);
    import aur_pkg::*;

    logic [COEF_W-1:0] r_beta, r_gamma;
    logic              ce;
    t_in_item          in_item;

    logic              f_valid;
    logic [NUM_W-1:0]  f_num;
    logic [DEN_W-1:0]  f_den;
    t_side             f_side;

    logic              d_valid;
    logic [QUO_B-1:0]  d_quo;
    logic              d_ovf;
    t_side             d_side;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta  <= BETA_RST;
            r_gamma <= GAMMA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BETA:  r_beta  <= i_cfg_data;
                REG_GAMMA: r_gamma <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless a result waits untaken
    assign ce         = !o_out.valid || o_out.ready;
    assign i_in.ready = ce;

    assign in_item.u_center       = i_in.u_center;
    assign in_item.u_east         = i_in.u_east;
    assign in_item.u_west         = i_in.u_west;
    assign in_item.u_north        = i_in.u_north;
    assign in_item.u_south        = i_in.u_south;
    assign in_item.g_value        = i_in.g_value;
    assign in_item.v_top_left     = i_in.v_top_left;
    assign in_item.v_top_right    = i_in.v_top_right;
    assign in_item.v_bottom_left  = i_in.v_bottom_left;
    assign in_item.v_bottom_right = i_in.v_bottom_right;
    assign in_item.on_border      = i_in.on_border;

    aur_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .i_beta  (r_beta),
        .o_valid (f_valid),
        .o_num   (f_num),
        .o_den   (f_den),
        .o_side  (f_side)
    );

    aur_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (f_valid),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_ovf   (d_ovf),
        .o_side  (d_side)
    );

    aur_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (d_valid),
        .i_quo   (d_quo),
        .i_ovf   (d_ovf),
        .i_side  (d_side),
        .i_gamma (r_gamma),
        .o_valid (o_out.valid),
        .o_new_u (o_out.new_u),
        .o_sq    (o_out.squared_change)
    );

endmodule
